FILE: src/focus_top2_depth_tracker_top_defines.svh
// assertion macros for the depth tracker checker
`ifndef FOCUS_TOP2_DEPTH_TRACKER_TOP_DEFINES_SVH
`define FOCUS_TOP2_DEPTH_TRACKER_TOP_DEFINES_SVH

// checked only outside reset
`define DTK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define DTK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/dtk_pkg.sv
// types, constants and weight table shared by the depth tracker modules
`timescale 1ns / 1ps
package dtk_pkg;

  localparam int unsigned PIXEL_COUNT_DEF = 65536;
  localparam int unsigned SLICE_COUNT_MAX = 256;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam longint unsigned W_DEN = 64'd5687411625;

  typedef logic [16:0] weight_tab_t [256];

  typedef struct packed {
    logic signed [24:0] best_score;
    logic [7:0]         best_slice;
    logic signed [24:0] second_score;
    logic [7:0]         second_slice;
  } entry_t;

  localparam entry_t ENTRY_INIT = '{
    best_score:   -25'sd1,
    best_slice:   8'd0,
    second_score: -25'sd1,
    second_slice: 8'd0
  };

  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  slice;
    logic        first;
    logic        in_range;
    logic [23:0] weighted;
  } item_t;

  typedef struct packed {
    entry_t      entry;
    logic [23:0] weighted;
  } res_t;

  // highlight weight in q1.16, smoothstep rolloff above gray 234
  function automatic logic [16:0] weight_of(input int unsigned g);
    longint unsigned v;
    longint unsigned num;
    longint unsigned x;
    v = longint'(g) * 100;
    if (v <= 23460) begin
      return 17'd65536;
    end
    num = v - 23460;
    if (num > 1785) begin
      num = 1785;
    end
    x = 49152 * num * num * (5355 - 2 * num);
    return 17'(65536 - (x + W_DEN / 2) / W_DEN);
  endfunction

  function automatic weight_tab_t build_weight_tab();
    weight_tab_t tab;
    for (int unsigned i = 0; i < 256; i++) begin
      tab[i] = weight_of(i);
    end
    return tab;
  endfunction

  localparam weight_tab_t WEIGHT_TAB = build_weight_tab();

endpackage

FILE: src/dtk_ram.sv
// simple dual-port ram with registered read
`timescale 1ns / 1ps
module dtk_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/dtk_fifo.sv
// small register queue with push/full and pop/empty sides
`timescale 1ns / 1ps
module dtk_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: src/dtk_front.sv
// front end: takes pixels, looks up the highlight weight and scales the score
`timescale 1ns / 1ps
module dtk_front #(
  parameter int unsigned PIXEL_COUNT = dtk_pkg::PIXEL_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [15:0]   pixel_addr,
  input  logic [7:0]    gray,
  input  logic [23:0]   focus_score,
  input  logic [7:0]    slice_index,
  input  logic          first_slice,
  output logic          out_valid,
  input  logic          out_ready,
  output dtk_pkg::item_t out_item
);
  import dtk_pkg::*;

  logic        s1_valid;
  logic        s1_valid_next;
  logic [15:0] s1_addr;
  logic [23:0] s1_score;
  logic [16:0] s1_wq;
  logic [7:0]  s1_slice;
  logic        s1_first;
  logic        accept;
  logic [7:0]  slice_sat;
  logic [40:0] prod;

  assign full   = s1_valid && !out_ready;
  assign accept = push && !full;

  assign slice_sat = ({9'd0, slice_index} >= 17'(SLICE_COUNT_MAX)) ?
                     8'(SLICE_COUNT_MAX - 1) : slice_index;

  always_comb begin
    s1_valid_next = s1_valid;
    if (accept) begin
      s1_valid_next = 1'b1;
    end else if (out_ready) begin
      s1_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr  <= pixel_addr;
      s1_score <= focus_score;
      s1_wq    <= WEIGHT_TAB[gray];
      s1_slice <= slice_sat;
      s1_first <= first_slice;
    end
  end

  assign prod = {17'd0, s1_score} * {24'd0, s1_wq};

  assign out_valid         = s1_valid;
  assign out_item.addr     = s1_addr;
  assign out_item.slice    = s1_slice;
  assign out_item.first    = s1_first;
  assign out_item.in_range = ({9'd0, s1_addr} < 25'(PIXEL_COUNT));
  assign out_item.weighted = prod[39:16];

endmodule

FILE: src/dtk_back.sv
// back end: per-pixel top-two store, read, update and write back
`timescale 1ns / 1ps
module dtk_back #(
  parameter int unsigned PIXEL_COUNT = dtk_pkg::PIXEL_COUNT_DEF,
  localparam int unsigned AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  output logic           q_pop,
  input  dtk_pkg::item_t q_item,
  input  logic           r_full,
  output logic           r_push,
  output dtk_pkg::res_t  r_data
);
  import dtk_pkg::*;

  logic           clearing;
  logic [AW-1:0]  clr_addr;
  logic           u_valid;
  logic           u_valid_next;
  item_t          u_item;
  logic           u_adv;
  logic           take;
  logic [AW+15:0] rd_ext;
  logic [AW+15:0] wr_ext;
  logic [$bits(entry_t)-1:0] ram_rdata;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  entry_t         ram_wdata;
  logic           byp_valid;
  logic [15:0]    byp_addr;
  entry_t         byp_entry;
  logic           byp_hit;
  entry_t         entry_old;
  entry_t         entry_new;
  logic signed [24:0] ws;

  assign u_adv = u_valid && !r_full;
  assign take  = !clearing && !q_empty && (!u_valid || u_adv);
  assign q_pop = take;

  assign rd_ext = {{AW{1'b0}}, q_item.addr};
  assign wr_ext = {{AW{1'b0}}, u_item.addr};

  always_comb begin
    u_valid_next = u_valid;
    if (take) begin
      u_valid_next = 1'b1;
    end else if (u_adv) begin
      u_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      u_valid   <= 1'b0;
      clearing  <= 1'b1;
      clr_addr  <= '0;
      byp_valid <= 1'b0;
    end else begin
      u_valid <= u_valid_next;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == AW'(PIXEL_COUNT - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (u_adv && u_item.in_range) begin
        byp_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      u_item <= q_item;
    end
    if (u_adv && u_item.in_range) begin
      byp_addr  <= u_item.addr;
      byp_entry <= entry_new;
    end
  end

  assign byp_hit = byp_valid && (byp_addr == u_item.addr);
  assign ws      = {1'b0, u_item.weighted};

  always_comb begin
    if (u_item.first || !u_item.in_range) begin
      entry_old = ENTRY_INIT;
    end else if (byp_hit) begin
      entry_old = byp_entry;
    end else begin
      entry_old = entry_t'(ram_rdata);
    end
    entry_new = entry_old;
    if (ws > entry_old.best_score) begin
      entry_new.second_score = entry_old.best_score;
      entry_new.second_slice = entry_old.best_slice;
      entry_new.best_score   = ws;
      entry_new.best_slice   = u_item.slice;
    end else if (ws > entry_old.second_score) begin
      entry_new.second_score = ws;
      entry_new.second_slice = u_item.slice;
    end
  end

  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = ENTRY_INIT;
    end else begin
      ram_we    = u_adv && u_item.in_range;
      ram_waddr = wr_ext[AW-1:0];
      ram_wdata = entry_new;
    end
  end

  dtk_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (PIXEL_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (take),
    .raddr (rd_ext[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign r_push          = u_adv;
  assign r_data.entry    = entry_new;
  assign r_data.weighted = u_item.weighted;

endmodule

FILE: src/focus_top2_depth_tracker_top.sv
// Focus-stack depth tracker: keeps the best and second-best highlight-weighted
// focus scores and their slice indices for every pixel, one result per pixel.
// Sustained rate is one pixel per clock while results are popped; pixels pass
// the input register with weight lookup, the multiplier into the middle queue,
// the store read, update and write into the result queue. The rate is set by
// the entry store, one read and one write per cycle, with a one-entry bypass
// for back-to-back pixels at the same address. After reset a clearing pass over
// all PIXEL_COUNT entries (65536 by default) sets every entry empty; pixels
// are taken until the front fills but no result leaves before it ends.
`timescale 1ns / 1ps
module focus_top2_depth_tracker_top #(
  parameter int unsigned PIXEL_COUNT = dtk_pkg::PIXEL_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [15:0]        pixel_addr,
  input  logic [7:0]         gray,
  input  logic [23:0]        focus_score,
  input  logic [7:0]         slice_index,
  input  logic               first_slice,
  output logic               empty,
  input  logic               pop,
  output logic signed [24:0] best_score,
  output logic [7:0]         best_slice,
  output logic signed [24:0] second_score,
  output logic [7:0]         second_slice,
  output logic [23:0]        weighted_score
);
  import dtk_pkg::*;

  logic  f_valid;
  logic  q_full;
  item_t f_item;
  logic  q_empty;
  logic  q_pop;
  item_t q_item;
  logic  r_full;
  logic  r_push;
  res_t  r_data;
  res_t  r_out;

  dtk_front #(
    .PIXEL_COUNT (PIXEL_COUNT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .pixel_addr  (pixel_addr),
    .gray        (gray),
    .focus_score (focus_score),
    .slice_index (slice_index),
    .first_slice (first_slice),
    .out_valid   (f_valid),
    .out_ready   (!q_full),
    .out_item    (f_item)
  );

  dtk_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_valid),
    .full  (q_full),
    .wdata (f_item),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_item)
  );

  dtk_back #(
    .PIXEL_COUNT (PIXEL_COUNT)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_item  (q_item),
    .r_full  (r_full),
    .r_push  (r_push),
    .r_data  (r_data)
  );

  dtk_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (r_push),
    .full  (r_full),
    .wdata (r_data),
    .pop   (pop),
    .empty (empty),
    .rdata (r_out)
  );

  assign best_score     = r_out.entry.best_score;
  assign best_slice     = r_out.entry.best_slice;
  assign second_score   = r_out.entry.second_score;
  assign second_slice   = r_out.entry.second_slice;
  assign weighted_score = r_out.weighted;

endmodule

FILE: src/dtk_checker.sv
// port-level checks for the depth tracker, bound to the top level
`timescale 1ns / 1ps
`include "focus_top2_depth_tracker_top_defines.svh"
module dtk_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [24:0] best_score,
  input logic [7:0]  best_slice,
  input logic [24:0] second_score,
  input logic [7:0]  second_slice,
  input logic [23:0] weighted_score
);

  logic [89:0] result_bits;
  logic        order_ok;

  assign result_bits = {best_score, best_slice, second_score, second_slice, weighted_score};
  assign order_ok    = ($signed(best_score) >= $signed(second_score)) &&
                       ($signed(best_score) >= $signed({1'b0, weighted_score}));

  // no result left after reset
  `DTK_ASSERT_ALWAYS(a_empty_after_rst, rst |=> empty, "result waiting after reset")

  // a waiting result that is not taken stays put
  `DTK_ASSERT(a_hold_result, !empty && !pop |=> !empty && $stable(result_bits), "result not held")

  // every transfer updates the entry, so the best is never the empty mark
  `DTK_ASSERT(a_best_set, !empty |-> !best_score[24], "best score still empty")

  // entry order and the item's own score against the best
  `DTK_ASSERT(a_order, !empty |-> order_ok, "best below second or item score")

endmodule

bind focus_top2_depth_tracker_top dtk_checker u_dtk_checker (.*);

FILE: tb/focus_top2_depth_tracker_top_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the focus-stack top-two depth tracker
module focus_top2_depth_tracker_top_tb;
  import dtk_pkg::*;

  localparam int unsigned NUM_PIXELS  = 1650;
  localparam int unsigned STALL_LIMIT = 262144;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam longint unsigned RAMP_DEN = 64'd5687411625;

  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  gray;
    logic [23:0] score;
    logic [7:0]  slice;
    logic        first;
  } pixel_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [15:0]        pixel_addr = '0;
  logic [7:0]         gray = '0;
  logic [23:0]        focus_score = '0;
  logic [7:0]         slice_index = '0;
  logic               first_slice = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [24:0] best_score;
  logic [7:0]         best_slice;
  logic signed [24:0] second_score;
  logic [7:0]         second_slice;
  logic [23:0]        weighted_score;

  pixel_t      pixel_q[$];
  res_t        ranked_q[$];
  entry_t      depth_mem[int unsigned];

  pixel_t      tx_px = '0;
  logic        tx_busy = 1'b0;
  int unsigned tx_wait = 0;
  int unsigned pushed = 0;

  res_t        rx_exp;
  logic        rx_ready = 1'b0;
  int unsigned rx_wait = 0;
  int unsigned rx_hold = 0;
  int unsigned popped = 0;

  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  logic        timed_out = 1'b0;

  focus_top2_depth_tracker_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .pixel_addr     (pixel_addr),
    .gray           (gray),
    .focus_score    (focus_score),
    .slice_index    (slice_index),
    .first_slice    (first_slice),
    .empty          (empty),
    .pop            (pop),
    .best_score     (best_score),
    .best_slice     (best_slice),
    .second_score   (second_score),
    .second_slice   (second_slice),
    .weighted_score (weighted_score)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // q1.16 highlight damping from the smoothstep rolloff
  function automatic logic [16:0] highlight_q16(input logic [7:0] g);
    longint unsigned lvl;
    longint unsigned ramp;
    longint unsigned cube;
    lvl = 64'(g) * 64'd100;
    if (lvl <= 64'd23460) begin
      return 17'h10000;
    end
    ramp = lvl - 64'd23460;
    if (ramp > 64'd1785) begin
      ramp = 64'd1785;
    end
    cube = 64'd49152 * ramp * ramp * (64'd5355 - 64'd2 * ramp);
    return 17'(64'd65536 - (cube + RAMP_DEN / 2) / RAMP_DEN);
  endfunction

  task automatic rank_pixel(input pixel_t px);
    entry_t             cur;
    res_t               exp_r;
    logic [40:0]        prod;
    logic signed [24:0] ws;
    prod = px.score * highlight_q16(px.gray);
    exp_r.weighted = prod[39:16];
    ws = $signed({1'b0, prod[39:16]});
    if (px.first || !depth_mem.exists(px.addr)) begin
      cur = ENTRY_INIT;
    end else begin
      cur = depth_mem[px.addr];
    end
    if (ws > $signed(cur.best_score)) begin
      cur.second_score = cur.best_score;
      cur.second_slice = cur.best_slice;
      cur.best_score = ws;
      cur.best_slice = px.slice;
    end else if (ws > $signed(cur.second_score)) begin
      cur.second_score = ws;
      cur.second_slice = px.slice;
    end
    depth_mem[px.addr] = cur;
    exp_r.entry = cur;
    ranked_q.push_back(exp_r);
  endtask

  // alternating stretches of random idling and none
  function automatic int unsigned gap_for(input int unsigned n);
    return ((n >> 7) & 1) ? 0 : $urandom_range(0, 15);
  endfunction

  task automatic add_pixel(input logic [15:0] a, input logic [7:0] g, input logic [23:0] sc,
                           input logic [7:0] sl, input logic fs);
    pixel_t px;
    px.addr = a;
    px.gray = g;
    px.score = sc;
    px.slice = sl;
    px.first = fs;
    pixel_q.push_back(px);
  endtask

  // one small patch of pixels across a run of slices
  task automatic add_stack();
    int unsigned base;
    int unsigned npix;
    int unsigned nsl;
    int unsigned sl0;
    logic        broken;
    logic [7:0]  g;
    logic [23:0] sc;
    base = $urandom_range(0, 65528);
    npix = $urandom_range(1, 8);
    nsl = $urandom_range(2, 8);
    sl0 = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255 - nsl) : 0;
    broken = ($urandom_range(0, 5) == 0);
    for (int unsigned s = 0; s < nsl; s++) begin
      for (int unsigned p = 0; p < npix; p++) begin
        g = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(230, 255)) : 8'($urandom);
        case ($urandom_range(0, 7))
          0: begin
            g = 8'd40;
            sc = 24'h00F000;
          end
          1: sc = 24'($urandom_range(0, 255));
          default: sc = 24'($urandom);
        endcase
        add_pixel(16'(base + p), g, sc, 8'(sl0 + s), (s == 0) && !broken);
      end
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      tx_busy = 1'b0;
      tx_wait = 0;
    end else begin
      if (push && !full) begin
        rank_pixel(tx_px);
        pushed++;
        tx_busy = 1'b0;
        tx_wait = gap_for(pushed + 64);
      end
      if (!tx_busy) begin
        if (tx_wait != 0) begin
          tx_wait--;
        end else if (pixel_q.size() != 0) begin
          tx_px = pixel_q.pop_front();
          tx_busy = 1'b1;
        end
      end
    end
    push <= tx_busy;
    pixel_addr <= tx_px.addr;
    gray <= tx_px.gray;
    focus_score <= tx_px.score;
    slice_index <= tx_px.slice;
    first_slice <= tx_px.first;
  end

  // receiver and result check
  always @(posedge clk) begin
    if (rst) begin
      rx_ready = 1'b0;
      rx_wait = 0;
    end else begin
      if (pop && !empty) begin
        if (ranked_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected transfer out at %0t", $time);
          end
        end else begin
          rx_exp = ranked_q.pop_front();
          if (best_score !== rx_exp.entry.best_score ||
              best_slice !== rx_exp.entry.best_slice ||
              second_score !== rx_exp.entry.second_score ||
              second_slice !== rx_exp.entry.second_slice ||
              weighted_score !== rx_exp.weighted) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d exp best %0d/%0d second %0d/%0d weighted %0h",
                       popped, $signed(rx_exp.entry.best_score), rx_exp.entry.best_slice,
                       $signed(rx_exp.entry.second_score), rx_exp.entry.second_slice,
                       rx_exp.weighted);
              $display("result %0d got best %0d/%0d second %0d/%0d weighted %0h",
                       popped, best_score, best_slice, second_score, second_slice,
                       weighted_score);
            end
          end
        end
        popped++;
        rx_ready = 1'b0;
        rx_wait = gap_for(popped);
        // long hold so the block fills and pushes back
        if (popped == 400 || popped == 1200) begin
          rx_hold = HOLD_CYCLES;
        end
      end
      if (!rx_ready) begin
        if (rx_hold != 0) begin
          rx_hold--;
        end else if (rx_wait == 0) begin
          rx_ready = 1'b1;
        end else begin
          rx_wait--;
        end
      end
    end
    pop <= rx_ready;
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT && !timed_out) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      timed_out = 1'b1;
    end
  end

  initial begin
    add_pixel(16'd0, 8'd0, 24'd0, 8'd0, 1'b1);
    add_pixel(16'd0, 8'd0, 24'd0, 8'd1, 1'b0);
    add_pixel(16'd0, 8'd0, 24'd0, 8'd2, 1'b0);
    add_pixel(16'd0, 8'd255, 24'hFFFFFF, 8'd3, 1'b0);
    add_pixel(16'd0, 8'd100, 24'h200000, 8'd4, 1'b0);
    add_pixel(16'd0, 8'd234, 24'hFFFFFF, 8'd5, 1'b0);
    add_pixel(16'd0, 8'd128, 24'd5, 8'd0, 1'b1);
    add_pixel(16'hFFFF, 8'd234, 24'hFFFFFF, 8'd255, 1'b1);
    add_pixel(16'hFFFF, 8'd235, 24'hFFFFFF, 8'd254, 1'b0);
    add_pixel(16'hFFFF, 8'd236, 24'h800000, 8'd253, 1'b0);
    add_pixel(16'hFFFF, 8'd240, 24'hFFFFFF, 8'd252, 1'b0);
    add_pixel(16'hFFFF, 8'd245, 24'hFFFFFF, 8'd251, 1'b0);
    add_pixel(16'hFFFF, 8'd250, 24'hFFFFFF, 8'd250, 1'b0);
    add_pixel(16'hFFFF, 8'd252, 24'hFFFFFF, 8'd249, 1'b0);
    add_pixel(16'hFFFF, 8'd254, 24'hFFFFFF, 8'd248, 1'b0);
    add_pixel(16'd1, 8'd10, 24'd1, 8'd0, 1'b1);
    add_pixel(16'd1, 8'd10, 24'd2, 8'd1, 1'b0);
    add_pixel(16'd1, 8'd10, 24'd3, 8'd2, 1'b0);
    add_pixel(16'hAAAA, 8'h55, 24'h5A5A5A, 8'hAA, 1'b1);
    add_pixel(16'h5555, 8'hAA, 24'hA5A5A5, 8'h55, 1'b0);
    while (pixel_q.size() < NUM_PIXELS) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          add_pixel(16'($urandom), 8'($urandom), 24'($urandom), 8'($urandom), 1'($urandom));
        end
      end else begin
        add_stack();
      end
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    do begin
      @(negedge clk);
    end while (!timed_out && (pixel_q.size() != 0 || tx_busy || ranked_q.size() != 0));
    if (!timed_out) begin
      repeat (10) @(posedge clk);
    end
    if (ranked_q.size() != 0) begin
      $display("%0d results never arrived", ranked_q.size());
    end
    if (!timed_out && mismatches == 0 && ranked_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
